// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the grid ray caster checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GRW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define GRW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/grw_pkg.sv =====
// ----------------------------------------------------------------------------
// grw_pkg
// shared constants, types and the sine table of the grid ray caster
// ----------------------------------------------------------------------------
`default_nettype none

package grw_pkg;

  localparam int MAP_SIZE     = 64;
  localparam int MAP_BITS     = $clog2(MAP_SIZE);
  localparam int FRAC_BITS    = 8;
  localparam int POS_W        = MAP_BITS + FRAC_BITS;
  localparam int ANGLE_W      = 13;
  localparam int FULL_TURN    = 5760;
  localparam int HALF_TURN    = 2880;
  localparam int QUARTER_TURN = 1440;
  localparam int ROM_AW       = 11;
  localparam int MAG_W        = 17;
  localparam int DIST_W       = 16;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam int STEP_LIMIT   = MAP_SIZE + 2;
  localparam int STEP_W       = $clog2(STEP_LIMIT + 1);
  localparam int LINE_W       = MAP_BITS + 3;
  localparam int D_W          = $clog2((STEP_LIMIT + 1) << FRAC_BITS) + 1;
  localparam int DVD_W        = MAG_W + 16;
  localparam int PROD_W       = D_W + DVD_W;
  localparam int Q_W          = PROD_W - 16 + 2;
  localparam int DATA_W       = 56;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // taylor series denominators (2k)(2k+1) for k = 1..7
  localparam longint unsigned TAYLOR_DEN [8] = '{1, 6, 20, 42, 72, 110, 156, 210};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_RAY   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    W_IDLE,
    W_SLOPE,
    W_STEP,
    W_CHECK,
    W_DIST
  } walk_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_ROM,
    B_RUN
  } back_state_e;

  // one classified item as it travels through the queue
  typedef struct packed {
    op_e                 op;
    logic [MAP_BITS-1:0] cell_x;
    logic [MAP_BITS-1:0] cell_y;
    logic                wall;
    logic [POS_W-1:0]    start_x;
    logic [POS_W-1:0]    start_y;
    logic [ROM_AW-1:0]   s_idx;
    logic [ROM_AW-1:0]   c_idx;
    logic                s_pos;
    logic                c_pos;
    logic                h_ok;
    logic                v_ok;
  } cmd_t;

  // map cell a walker looks at: line index on its own axis, cell on the other
  typedef struct packed {
    logic [MAP_BITS-1:0] line;
    logic [MAP_BITS-1:0] perp;
  } cell_addr_t;

  typedef logic [MAG_W-1:0] sine_rom_t [QUARTER_TURN+1];

  // quarter-wave sine, Q16, from an integer Taylor series at Q30
  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint sum;
    for (int a = 0; a <= QUARTER_TURN; a++) begin
      x = (longint'(a) * PI_Q30) / HALF_TURN;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DEN[k];
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) + 8192) >> 14;
      if (v > 65536) v = 65536;
      rom[a] = MAG_W'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

endpackage

`default_nettype wire

// ===== src/grw_front.sv =====
// ----------------------------------------------------------------------------
// grw_front
// accepts items, reduces the angle, picks table indices, queues the result
// ----------------------------------------------------------------------------
`default_nettype none

module grw_front import grw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              in_op_i,
  input  wire logic [DATA_W-1:0] in_data_i,
  input  wire logic              hold_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output cmd_t                   cmd_o
);

  logic [ANGLE_W-1:0] angle;
  logic [ANGLE_W-1:0] a_red;
  logic [ANGLE_W-1:0] a_cos;
  logic [ANGLE_W-1:0] a_cos_red;
  cmd_t               cmd_new;
  cmd_t               fifo_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               push;
  logic               pop;

  // fold an angle in one turn onto the quarter-wave table
  function automatic logic [ROM_AW-1:0] fold(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] r;
    r = (a >= ANGLE_W'(HALF_TURN)) ? a - ANGLE_W'(HALF_TURN) : a;
    if (r > ANGLE_W'(QUARTER_TURN)) r = ANGLE_W'(HALF_TURN) - r;
    return r[ROM_AW-1:0];
  endfunction

  // angle reduction and quadrant flags
  always_comb begin
    angle     = in_data_i[25:13];
    a_red     = (angle >= ANGLE_W'(FULL_TURN)) ? angle - ANGLE_W'(FULL_TURN) : angle;
    a_cos     = a_red + ANGLE_W'(QUARTER_TURN);
    a_cos_red = (a_cos >= ANGLE_W'(FULL_TURN)) ? a_cos - ANGLE_W'(FULL_TURN) : a_cos;

    cmd_new.op      = op_e'(in_op_i);
    cmd_new.cell_x  = in_data_i[5:0];
    cmd_new.cell_y  = in_data_i[11:6];
    cmd_new.wall    = in_data_i[12];
    cmd_new.start_x = in_data_i[39:26];
    cmd_new.start_y = in_data_i[53:40];
    cmd_new.s_idx   = fold(a_red);
    cmd_new.c_idx   = fold(a_cos_red);
    cmd_new.s_pos   = (a_red != '0) && (a_red < ANGLE_W'(HALF_TURN));
    cmd_new.c_pos   = (a_red < ANGLE_W'(QUARTER_TURN)) ||
                      (a_red > ANGLE_W'(HALF_TURN + QUARTER_TURN));
    cmd_new.h_ok    = (a_red != '0) && (a_red != ANGLE_W'(HALF_TURN));
    cmd_new.v_ok    = (a_red != ANGLE_W'(QUARTER_TURN)) &&
                      (a_red != ANGLE_W'(HALF_TURN + QUARTER_TURN));
  end

  // two-entry queue toward the back end
  assign in_ready_o  = (cnt_q != 2'd2) && !hold_i;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_new;
  end

endmodule

`default_nettype wire

// ===== src/grw_div.sv =====
// ----------------------------------------------------------------------------
// grw_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module grw_div import grw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [MAG_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quot_q, quot_d;
  logic [MAG_W-1:0] div_q, div_d;
  logic [MAG_W:0]   trial;
  logic             ge;

  // one shift-subtract step
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    div_d  = div_q;
    trial  = {rem_q, quot_q[DVD_W-1]};
    ge     = trial >= {1'b0, div_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quot_d = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? MAG_W'(trial - {1'b0, div_q}) : trial[MAG_W-1:0];
      quot_d = {quot_q[DVD_W-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== src/grw_walk.sv =====
// ----------------------------------------------------------------------------
// grw_walk
// walks one set of grid lines until a wall, the map edge or the step limit
// ----------------------------------------------------------------------------
`default_nettype none

module grw_walk import grw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              en_i,
  input  wire logic [POS_W-1:0]  p0_i,
  input  wire logic [POS_W-1:0]  q0_i,
  input  wire logic              pup_i,
  input  wire logic              qup_i,
  input  wire logic [MAG_W-1:0]  num_i,
  input  wire logic [MAG_W-1:0]  mag_i,
  output cell_addr_t             addr_o,
  input  wire logic              cell_i,
  output logic                   busy_o,
  output logic [DIST_W-1:0]      dist_o
);

  walk_state_e              state_q, state_d;
  logic signed [LINE_W-1:0] line_q, line_d;
  logic [D_W-1:0]           d_q, d_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  logic [DVD_W-1:0]         slope_q, slope_d;
  logic [STEP_W-1:0]        i_q, i_d;
  logic [DIST_W-1:0]        dist_q, dist_d;
  logic [POS_W-1:0]         q0_q, q0_d;
  logic                     pup_q, pup_d;
  logic                     qup_q, qup_d;
  logic [MAG_W-1:0]         mag_q, mag_d;
  logic [POS_W:0]           p_round;
  logic signed [LINE_W-1:0] li;
  logic signed [Q_W-1:0]    q_pos;
  logic signed [Q_W-1:0]    off;
  logic                     li_oob;
  logic                     q_oob;
  logic                     div_start;
  logic [DVD_W-1:0]         div_dvd;
  logic                     div_done;
  logic [DVD_W-1:0]         div_quot;

  grw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  ((state_q == W_IDLE) ? mag_i : mag_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // current cell and the map-edge test
  always_comb begin
    li     = line_q - (pup_q ? LINE_W'(0) : LINE_W'(1));
    off    = Q_W'(prod_q[PROD_W-1:16]);
    q_pos  = qup_q ? Q_W'(q0_q) + off : Q_W'(q0_q) - off;
    li_oob = li[LINE_W-1:MAP_BITS] != '0;
    q_oob  = q_pos[Q_W-1:POS_W] != '0;
    addr_o.line = li[MAP_BITS-1:0];
    addr_o.perp = q_pos[POS_W-1:FRAC_BITS];
    p_round = {1'b0, p0_i} + (POS_W+1)'((1 << FRAC_BITS) - 1);
  end

  // walker sequencer
  always_comb begin
    state_d   = state_q;
    line_d    = line_q;
    d_d       = d_q;
    prod_d    = prod_q;
    slope_d   = slope_q;
    i_d       = i_q;
    dist_d    = dist_q;
    q0_d      = q0_q;
    pup_d     = pup_q;
    qup_d     = qup_q;
    mag_d     = mag_q;
    div_start = 1'b0;
    div_dvd   = DVD_W'({d_q, 16'b0});
    case (state_q)
      W_IDLE: begin
        if (start_i) begin
          q0_d  = q0_i;
          pup_d = pup_i;
          qup_d = qup_i;
          mag_d = mag_i;
          i_d   = '0;
          if (pup_i) begin
            line_d = LINE_W'(p_round[POS_W:FRAC_BITS]);
            d_d    = D_W'({p_round[POS_W:FRAC_BITS], {FRAC_BITS{1'b0}}} - {1'b0, p0_i});
          end else begin
            line_d = LINE_W'(p0_i[POS_W-1:FRAC_BITS]);
            d_d    = D_W'(p0_i[FRAC_BITS-1:0]);
          end
          if (en_i) begin
            div_start = 1'b1;
            div_dvd   = {num_i, 16'b0};
            state_d   = W_SLOPE;
          end else begin
            dist_d = DIST_MAX;
          end
        end
      end
      W_SLOPE: begin
        if (div_done) begin
          slope_d = div_quot;
          prod_d  = PROD_W'(d_q[FRAC_BITS-1:0] * div_quot);
          state_d = W_STEP;
        end
      end
      W_STEP: begin
        if ((i_q == STEP_W'(STEP_LIMIT)) || li_oob || q_oob) begin
          div_start = 1'b1;
          state_d   = W_DIST;
        end else begin
          state_d = W_CHECK;
        end
      end
      W_CHECK: begin
        if (cell_i) begin
          div_start = 1'b1;
          state_d   = W_DIST;
        end else begin
          line_d  = pup_q ? line_q + LINE_W'(1) : line_q - LINE_W'(1);
          d_d     = d_q + D_W'(1 << FRAC_BITS);
          prod_d  = prod_q + (PROD_W'(slope_q) << FRAC_BITS);
          i_d     = i_q + 1'b1;
          state_d = W_STEP;
        end
      end
      W_DIST: begin
        if (div_done) begin
          dist_d  = (div_quot > DVD_W'(DIST_MAX)) ? DIST_MAX : div_quot[DIST_W-1:0];
          state_d = W_IDLE;
        end
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q  <= line_d;
    d_q     <= d_d;
    prod_q  <= prod_d;
    slope_q <= slope_d;
    i_q     <= i_d;
    dist_q  <= dist_d;
    q0_q    <= q0_d;
    pup_q   <= pup_d;
    qup_q   <= qup_d;
    mag_q   <= mag_d;
  end

  assign busy_o = (state_q != W_IDLE);
  assign dist_o = dist_q;

endmodule

`default_nettype wire

// ===== src/grw_back.sv =====
// ----------------------------------------------------------------------------
// grw_back
// map memory, sine table, the two walkers and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module grw_back import grw_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cmd_valid_i,
  output logic              cmd_ready_o,
  input  wire cmd_t         cmd_i,
  output logic              clearing_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [DIST_W-1:0] out_dist_o,
  output logic              out_vert_o
);

  back_state_e         state_q, state_d;
  logic [MAP_BITS-1:0] clr_q, clr_d;
  logic [MAP_SIZE-1:0] map_q [MAP_SIZE];
  cmd_t                cmd_q;
  logic [MAG_W-1:0]    s_mag_q;
  logic [MAG_W-1:0]    c_mag_q;
  logic                rd_h_q;
  logic                rd_v_q;
  logic                pop;
  logic                map_wr;
  logic                walk_start;
  logic                load_out;
  logic                out_free;
  cell_addr_t          h_addr;
  cell_addr_t          v_addr;
  logic                h_busy;
  logic                v_busy;
  logic [DIST_W-1:0]   h_dist;
  logic [DIST_W-1:0]   v_dist;
  logic                out_valid_q;
  logic [DIST_W-1:0]   out_dist_q;
  logic                out_vert_q;

  assign pop      = cmd_valid_i && cmd_ready_o;
  assign map_wr   = pop && (cmd_i.op == OP_WRITE);
  assign out_free = !out_valid_q || out_ready_i;

  // sequencer: clearing pass, then one item at a time
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_ready_o = 1'b0;
    clearing_o  = 1'b0;
    walk_start  = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      B_CLEAR: begin
        clearing_o = 1'b1;
        clr_d      = clr_q + 1'b1;
        if (clr_q == MAP_BITS'(MAP_SIZE - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i && (cmd_i.op == OP_RAY)) state_d = B_ROM;
      end
      B_ROM: begin
        walk_start = 1'b1;
        state_d    = B_RUN;
      end
      B_RUN: begin
        if (!h_busy && !v_busy && out_free) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // map memory: one write port, one read port per walker
  always_ff @(posedge clk_i) begin
    if (clearing_o) begin
      map_q[clr_q] <= '0;
    end else if (map_wr) begin
      map_q[cmd_i.cell_x][cmd_i.cell_y] <= cmd_i.wall;
    end
    rd_h_q <= map_q[h_addr.perp][h_addr.line];
    rd_v_q <= map_q[v_addr.line][v_addr.perp];
  end

  // latch the ray and read both table magnitudes
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q   <= cmd_i;
      s_mag_q <= SINE_ROM[cmd_i.s_idx];
      c_mag_q <= SINE_ROM[cmd_i.c_idx];
    end
  end

  // walker over horizontal lines
  grw_walk u_walk_h (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start),
    .en_i    (cmd_q.h_ok && (s_mag_q != '0)),
    .p0_i    (cmd_q.start_y),
    .q0_i    (cmd_q.start_x),
    .pup_i   (cmd_q.s_pos),
    .qup_i   (cmd_q.c_pos),
    .num_i   (c_mag_q),
    .mag_i   (s_mag_q),
    .addr_o  (h_addr),
    .cell_i  (rd_h_q),
    .busy_o  (h_busy),
    .dist_o  (h_dist)
  );

  // walker over vertical lines
  grw_walk u_walk_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start),
    .en_i    (cmd_q.v_ok && (c_mag_q != '0)),
    .p0_i    (cmd_q.start_x),
    .q0_i    (cmd_q.start_y),
    .pup_i   (cmd_q.c_pos),
    .qup_i   (cmd_q.s_pos),
    .num_i   (s_mag_q),
    .mag_i   (c_mag_q),
    .addr_o  (v_addr),
    .cell_i  (rd_v_q),
    .busy_o  (v_busy),
    .dist_o  (v_dist)
  );

  // result register, nearer hit wins, ties go horizontal
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_vert_q <= v_dist < h_dist;
      out_dist_q <= (v_dist < h_dist) ? v_dist : h_dist;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dist_o  = out_dist_q;
  assign out_vert_o  = out_vert_q;

endmodule

`default_nettype wire

// ===== src/grid_ray_wall_distance.sv =====
// ----------------------------------------------------------------------------
// grid_ray_wall_distance
// grid ray caster: 64x64 wall map, nearest wall distance per ray
// ----------------------------------------------------------------------------
// Input stream carries two kinds of item, chosen by s_axis_tuser: a map write
// (one cell, no result) or a ray (start point and angle, one result).
// Output stream returns the distance (8 fraction bits, saturating) and a flag
// for a hit on a vertical grid line.
// A front stage classifies items into a two-entry queue; the back end runs
// them one at a time. A write is done in the back end's idle state. A ray
// goes through a slope division, up to 66 line steps (one map read per
// step) and a distance division, with both walkers running side by side.
// Reset clears the map in a pass of one row per cycle; no item is accepted
// during it. A result waits in the output register while the receiver
// stalls; the queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_wall_distance import grw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // cell_x, cell_y, cell_is_wall, ray_angle, start_x, start_y, zero pad
  input  wire logic [DATA_W-1:0] s_axis_tdata,
  // opcode
  input  wire logic              s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // distance
  output logic [DIST_W-1:0]      m_axis_tdata,
  // hit_vertical
  output logic                   m_axis_tuser
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic clearing;

  grw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .hold_i      (clearing),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  grw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .clearing_o  (clearing),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_dist_o  (m_axis_tdata),
    .out_vert_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== src/grw_checker.sv =====
// ----------------------------------------------------------------------------
// grw_checker
// port-level checks of the grid ray caster, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module grw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [55:0] s_axis_tdata,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // a stalled result stays offered
  `GRW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

  // a stalled result keeps its value
  `GRW_ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // map clearing blocks input right after reset
  `GRW_ASSERT_IMP(a_clear_block, clk_i, rst_ni, $rose(rst_ni), !s_axis_tready, "input taken during map clear")

  // a vertical hit was strictly nearer, so never saturated
  `GRW_ASSERT_IMP(a_vert_near, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata != 16'hFFFF, "vertical hit at saturated distance")

endmodule

bind grid_ray_wall_distance grw_checker u_grw_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the grid ray caster
// ----------------------------------------------------------------------------
// Map writes and rays stream in with random gaps; the receiver stalls at
// random. A local predictor keeps its own copy of the wall map and sine table,
// walks both grid-line axes per ray and queues the expected distance and flag.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import grw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    op_e         op;
    logic [5:0]  cx;
    logic [5:0]  cy;
    logic        wall;
    logic [12:0] angle;
    logic [13:0] sx;
    logic [13:0] sy;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] len;
    logic        vert;
  } hit_t;

  localparam int LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DIST_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  cmd_item_t pending_q[$];
  hit_t hits_q[$];
  bit wall_map [64*64];
  longint unsigned sine_tab [QUARTER_TURN+1];
  int mismatches = 0;
  int cycles = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;

  grid_ray_wall_distance DUT (.*);

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // quarter-wave sine table, Q16
  function automatic void make_sine();
    longint unsigned x, x2, term, v;
    longint sum;
    for (int a = 0; a <= QUARTER_TURN; a++) begin
      x = (longint'(a) * 64'd3373259426) / HALF_TURN;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) + 8192) >> 14;
      if (v > 65536) v = 65536;
      sine_tab[a] = v;
    end
  endfunction

  function automatic longint unsigned sine_mag(int a);
    int r;
    r = a % HALF_TURN;
    if (r > QUARTER_TURN) r = HALF_TURN - r;
    return sine_tab[r];
  endfunction

  // walk one axis of grid lines to the first wall or the map edge
  function automatic longint unsigned line_walk(longint p0, longint q0, bit pup,
      bit qup, longint unsigned slope, longint unsigned mag, bit rows);
    longint line, lower, off, q, li;
    longint unsigned d, dlen;
    if (pup) begin
      line = (p0 + 255) >>> 8;
      d = (line << 8) - p0;
      lower = 0;
    end else begin
      line = p0 >>> 8;
      d = p0 & 255;
      lower = 1;
    end
    for (int i = 0; i < 66; i++) begin
      off = longint'((d * slope) >> 16);
      q = qup ? q0 + off : q0 - off;
      li = line - lower;
      if (li < 0 || li >= 64 || q < 0 || q >= 64 * 256) break;
      if (rows ? wall_map[(q >>> 8) * 64 + li] : wall_map[li * 64 + (q >>> 8)]) break;
      line += pup ? 1 : -1;
      d += 256;
    end
    dlen = (d << 16) / mag;
    return dlen > 65535 ? 65535 : dlen;
  endfunction

  // expected hit for one accepted item, map update for writes
  function automatic void predict_hit(cmd_item_t it);
    int a;
    longint unsigned s, c, dh, dv;
    bit sp, cp;
    hit_t h;
    if (it.op == OP_WRITE) begin
      wall_map[it.cx * 64 + it.cy] = it.wall;
      return;
    end
    a = int'(it.angle) % FULL_TURN;
    s = sine_mag(a);
    c = sine_mag((a + QUARTER_TURN) % FULL_TURN);
    sp = a > 0 && a < HALF_TURN;
    cp = a < QUARTER_TURN || a > HALF_TURN + QUARTER_TURN;
    dh = 65535;
    dv = 65535;
    if (a != 0 && a != HALF_TURN && s != 0)
      dh = line_walk(it.sy, it.sx, sp, cp, (c << 16) / s, s, 1'b1);
    if (a != QUARTER_TURN && a != HALF_TURN + QUARTER_TURN && c != 0)
      dv = line_walk(it.sx, it.sy, cp, sp, (s << 16) / c, c, 1'b0);
    if (dv < dh) h = '{len: dv[15:0], vert: 1'b1};
    else h = '{len: dh[15:0], vert: 1'b0};
    hits_q.push_back(h);
  endfunction

  function automatic cmd_item_t ray(int ang, int x, int y);
    cmd_item_t it;
    it = '0;
    it.op = OP_RAY;
    it.angle = 13'(ang);
    it.sx = 14'(x);
    it.sy = 14'(y);
    return it;
  endfunction

  function automatic cmd_item_t cell_wr(int x, int y, bit w);
    cmd_item_t it;
    it = '0;
    it.op = OP_WRITE;
    it.cx = 6'(x);
    it.cy = 6'(y);
    it.wall = w;
    return it;
  endfunction

  // stretch without idling while the middle of the stimulus goes out
  always @(posedge clk_i) begin
    calm <= (pending_q.size() >= 700) && (pending_q.size() < 950);
  end

  // driver
  always @(posedge clk_i) begin
    cmd_item_t it;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
          it = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= it.op;
          s_axis_tdata <= DATA_W'({it.sy, it.sx, it.angle, it.wall, it.cy, it.cx});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // predictor on input acceptance
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predict_hit(cmd_item_t'({op_e'(s_axis_tuser), s_axis_tdata[5:0], s_axis_tdata[11:6],
          s_axis_tdata[12], s_axis_tdata[25:13], s_axis_tdata[39:26],
          s_axis_tdata[53:40]}));
  end

  // monitor and receiver stalls
  always @(posedge clk_i) begin
    hit_t exp_h;
    cycles <= cycles + 1;
    if (rst_ni) begin
      m_axis_tready <= calm || ($urandom_range(99) >= 32);
      if (m_axis_tvalid && m_axis_tready) begin
        if (hits_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result dist=%0d vert=%0b",
              m_axis_tdata, m_axis_tuser);
        end else begin
          exp_h = hits_q.pop_front();
          if (exp_h.len !== m_axis_tdata || exp_h.vert !== m_axis_tuser) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected dist=%0d vert=%0b, got dist=%0d vert=%0b",
                  exp_h.len, exp_h.vert, m_axis_tdata, m_axis_tuser);
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int n;
    make_sine();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty map, axis angles, extremes
    pending_q.push_back(ray(0, 32 << 8, 32 << 8));
    pending_q.push_back(ray(1440, 32 << 8, 32 << 8));
    pending_q.push_back(ray(2880, 32 << 8, 32 << 8));
    pending_q.push_back(ray(4320, 32 << 8, 32 << 8));
    pending_q.push_back(ray(720, 0, 0));
    pending_q.push_back(ray(8191, 16383, 16383));
    pending_q.push_back(ray(5759, 16383, 0));
    pending_q.push_back(ray(5760, 100, 100));
    pending_q.push_back(cell_wr(63, 63, 1'b1));
    pending_q.push_back(cell_wr(0, 0, 1'b1));
    pending_q.push_back(cell_wr(40, 32, 1'b1));
    pending_q.push_back(cell_wr(32, 40, 1'b1));
    pending_q.push_back(ray(0, 32 << 8, 32 << 8));
    pending_q.push_back(ray(1440, 32 << 8, 32 << 8));
    pending_q.push_back(ray(720, 60 << 8, 60 << 8));
    pending_q.push_back(ray(3600, 3 << 8, 3 << 8));
    pending_q.push_back(ray(720, (36 << 8) + 128, (36 << 8) + 128));
    pending_q.push_back(cell_wr(40, 32, 1'b0));
    pending_q.push_back(ray(0, 32 << 8, 32 << 8));
    pending_q.push_back(ray(1, 5, 16383));
    pending_q.push_back(ray(1439, 16383, 5));

    // random: mostly rays inside the map against a changing map
    for (int i = 0; i < 1830; i++) begin
      n = $urandom_range(99);
      if (n < 45) pending_q.push_back(cell_wr($urandom_range(63), $urandom_range(63),
          $urandom_range(99) < 60));
      else if (n < 90) pending_q.push_back(ray($urandom_range(5759),
          $urandom_range((64 << 8) - 1), $urandom_range((64 << 8) - 1)));
      else pending_q.push_back(ray($urandom_range(8191), $urandom_range(16383),
          $urandom_range(16383)));
    end

    while ((pending_q.size() > 0 || s_axis_tvalid || hits_q.size() > 0) && cycles < LIMIT)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (cycles >= LIMIT) begin
      $display("*** FAILED ***");
    end else if (mismatches == 0 && hits_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
